// ===== rtl/mrf_pkg.sv =====
// Shared types, codes and the CRC-16/Modbus byte update for the RTU master framer.
package mrf_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// action field of an input word
	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_RX      = 1'b1;

	// kind field of a result word
	localparam logic [1:0] KIND_REQ_BYTE = 2'd0;
	localparam logic [1:0] KIND_WORD     = 2'd1;
	localparam logic [1:0] KIND_STATUS   = 2'd2;

	// byte positions within the eight-byte request frame
	localparam logic [2:0] REQ_IDX_SLAVE   = 3'd0;
	localparam logic [2:0] REQ_IDX_FUNC    = 3'd1;
	localparam logic [2:0] REQ_IDX_ADDR_HI = 3'd2;
	localparam logic [2:0] REQ_IDX_ADDR_LO = 3'd3;
	localparam logic [2:0] REQ_IDX_CNT_HI  = 3'd4;
	localparam logic [2:0] REQ_IDX_CNT_LO  = 3'd5;
	localparam logic [2:0] REQ_IDX_CRC_LO  = 3'd6;
	localparam logic [2:0] REQ_IDX_CRC_HI  = 3'd7;

	typedef struct packed {
		logic        action;
		logic [7:0]  unit_id;
		logic [7:0]  function_code;
		logic [15:0] start_address;
		logic [15:0] reg_count;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [15:0] reg_address;
		logic [15:0] reg_value;
		logic        crc_ok;
		logic        last;
	} result_t;

	// work handed from front end to back end
	typedef enum logic [1:0] {
		CMD_REQ    = 2'd0,
		CMD_WORD   = 2'd1,
		CMD_STATUS = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  unit_id;
		logic [7:0]  function_code;
		logic [15:0] address;    // start address (request) or register address (word)
		logic [15:0] value;      // register count (request) or data word
		logic        crc_ok;
	} cmd_t;

	// receive phase, one-hot
	typedef enum logic [7:0] {
		PH_HDR0 = 8'b0000_0001,
		PH_HDR1 = 8'b0000_0010,
		PH_CNT  = 8'b0000_0100,
		PH_DHI  = 8'b0000_1000,
		PH_DLO  = 8'b0001_0000,
		PH_CRCL = 8'b0010_0000,
		PH_CRCH = 8'b0100_0000,
		PH_DONE = 8'b1000_0000
	} phase_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/modbus_rtu_master_framer.sv =====
// Top level of the Modbus RTU master framer: front end, work queue and back end.
// A request word (action 0) yields the eight-byte request frame - slave id, function code,
// start address and register count big-endian, then CRC-16/Modbus low byte first - and
// re-arms the response receiver. A receive word (action 1) carries one response byte; each
// completed big-endian data word comes out at once tagged with start address plus index,
// and the last byte of the frame yields a status word whose crc_ok must be 1 before the
// consumer trusts the words before it. Bytes after the frame end are dropped until the
// next request. Input words are taken one per cycle whenever full is low; receive bytes
// that finish nothing never occupy the queue. The result side delivers one word per cycle
// whenever the result register is empty or popped, so a request frame occupies the back
// end for all eight of its bytes while the front end keeps taking bytes into the
// QUEUE_DEPTH-entry queue. A result passes through a queue slot, written at the edge
// that accepts its input word, and then through the result register.
module modbus_rtu_master_framer #(
	parameter int QUEUE_DEPTH = 4    // 2 or more
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  mrf_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output mrf_pkg::result_t result
);

	logic          accept;
	logic          cmd_valid;
	mrf_pkg::cmd_t cmd_in;
	mrf_pkg::cmd_t cmd_head;
	logic          cmd_empty;
	logic          cmd_pop;

	// a word is taken whenever the queue has room, even if it will not need it
	assign accept = push && !full;

	mrf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	mrf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty)
	);

	mrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== rtl/mrf_front.sv =====
// Front end: takes input words, runs the response receiver and issues work to the queue.
module mrf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  mrf_pkg::item_t  item,
	output logic            cmd_valid,
	output mrf_pkg::cmd_t   cmd
);

	mrf_pkg::phase_t phase_q;
	logic [15:0]     crc_q;
	logic [7:0]      total_q;
	logic [15:0]     base_q;
	logic [6:0]      widx_q;
	logic [7:0]      hi_q;
	logic [7:0]      lo_q;
	logic            seen_q;
	logic [15:0]     crc_next;
	logic            rx_take;

	assign crc_next = mrf_pkg::crc_byte(crc_q, item.rx_byte);
	assign rx_take  = accept && (item.action == mrf_pkg::ACT_RX);

	always_comb begin
		cmd       = '0;
		cmd_valid = 1'b0;
		if (accept) begin
			if (item.action == mrf_pkg::ACT_REQUEST) begin
				cmd_valid          = 1'b1;
				cmd.kind           = mrf_pkg::CMD_REQ;
				cmd.unit_id        = item.unit_id;
				cmd.function_code  = item.function_code;
				cmd.address        = item.start_address;
				cmd.value          = item.reg_count;
			end else begin
				unique case (phase_q)
					mrf_pkg::PH_DLO: begin
						cmd_valid   = 1'b1;
						cmd.kind    = mrf_pkg::CMD_WORD;
						cmd.address = base_q + {9'd0, widx_q};
						cmd.value   = {hi_q, item.rx_byte};
					end
					mrf_pkg::PH_CRCH: begin
						cmd_valid  = 1'b1;
						cmd.kind   = mrf_pkg::CMD_STATUS;
						cmd.crc_ok = ({item.rx_byte, lo_q} == crc_q) && seen_q;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mrf_pkg::PH_HDR0;
			crc_q   <= mrf_pkg::CRC_INIT;
			total_q <= 8'd0;
			base_q  <= 16'd0;
			widx_q  <= 7'd0;
			seen_q  <= 1'b0;
		end else if (accept && (item.action == mrf_pkg::ACT_REQUEST)) begin
			phase_q <= mrf_pkg::PH_HDR0;
			crc_q   <= mrf_pkg::CRC_INIT;
			total_q <= 8'd0;
			base_q  <= item.start_address;
			widx_q  <= 7'd0;
			seen_q  <= 1'b1;
		end else if (rx_take) begin
			unique case (phase_q)
				mrf_pkg::PH_HDR0: begin
					crc_q   <= crc_next;
					phase_q <= mrf_pkg::PH_HDR1;
				end
				mrf_pkg::PH_HDR1: begin
					crc_q   <= crc_next;
					phase_q <= mrf_pkg::PH_CNT;
				end
				mrf_pkg::PH_CNT: begin
					crc_q   <= crc_next;
					total_q <= item.rx_byte;
					phase_q <= (item.rx_byte == 8'd0) ? mrf_pkg::PH_CRCL : mrf_pkg::PH_DHI;
				end
				mrf_pkg::PH_DHI: begin
					crc_q   <= crc_next;
					total_q <= total_q - 8'd1;
					phase_q <= (total_q == 8'd1) ? mrf_pkg::PH_CRCL : mrf_pkg::PH_DLO;
				end
				mrf_pkg::PH_DLO: begin
					crc_q   <= crc_next;
					total_q <= total_q - 8'd1;
					widx_q  <= widx_q + 7'd1;
					phase_q <= (total_q == 8'd1) ? mrf_pkg::PH_CRCL : mrf_pkg::PH_DHI;
				end
				mrf_pkg::PH_CRCL: phase_q <= mrf_pkg::PH_CRCH;
				mrf_pkg::PH_CRCH: phase_q <= mrf_pkg::PH_DONE;
				mrf_pkg::PH_DONE: ;
				default:          phase_q <= mrf_pkg::PH_DONE;
			endcase
		end
	end

	// data high byte and CRC low byte holds
	always_ff @(posedge clk) begin
		if (rx_take && (phase_q == mrf_pkg::PH_DHI)) begin
			hi_q <= item.rx_byte;
		end
		if (rx_take && (phase_q == mrf_pkg::PH_CRCL)) begin
			lo_q <= item.rx_byte;
		end
	end

endmodule

// ===== rtl/mrf_queue.sv =====
// Short first-in first-out queue of work between front end and back end.
module mrf_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  mrf_pkg::cmd_t  wr_data,
	output logic           full,
	input  logic           rd_en,
	output mrf_pkg::cmd_t  rd_data,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DEPTH);

	mrf_pkg::cmd_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_TOP);
	assign empty   = (count_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_TOP) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_TOP) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/mrf_back.sv =====
// Back end: serialises request frames with their CRC and drives the result register.
module mrf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  mrf_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output mrf_pkg::result_t result
);

	logic             req_active_q;
	logic [2:0]       idx_q;
	logic [15:0]      crc_q;
	logic [7:0]       func_q;
	logic [15:0]      addr_q;
	logic [15:0]      cnt_q;
	logic             out_valid_q;
	mrf_pkg::result_t out_q;

	logic             out_free;
	logic             load;
	logic [7:0]       req_byte;
	mrf_pkg::result_t next_out;
	logic             start_req;

	assign out_free  = !out_valid_q || pop;
	assign cmd_pop   = out_free && !req_active_q && !cmd_empty;
	assign load      = out_free && (req_active_q || !cmd_empty);
	assign start_req = cmd_pop && (cmd.kind == mrf_pkg::CMD_REQ);
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_comb begin
		unique case (idx_q)
			mrf_pkg::REQ_IDX_FUNC:    req_byte = func_q;
			mrf_pkg::REQ_IDX_ADDR_HI: req_byte = addr_q[15:8];
			mrf_pkg::REQ_IDX_ADDR_LO: req_byte = addr_q[7:0];
			mrf_pkg::REQ_IDX_CNT_HI:  req_byte = cnt_q[15:8];
			mrf_pkg::REQ_IDX_CNT_LO:  req_byte = cnt_q[7:0];
			mrf_pkg::REQ_IDX_CRC_LO:  req_byte = crc_q[7:0];
			mrf_pkg::REQ_IDX_CRC_HI:  req_byte = crc_q[15:8];
			default:                  req_byte = 8'h00;
		endcase
	end

	always_comb begin
		next_out = '0;
		if (req_active_q) begin
			next_out.kind     = mrf_pkg::KIND_REQ_BYTE;
			next_out.out_byte = req_byte;
			next_out.last     = (idx_q == mrf_pkg::REQ_IDX_CRC_HI);
		end else begin
			unique case (cmd.kind)
				mrf_pkg::CMD_REQ: begin
					next_out.kind     = mrf_pkg::KIND_REQ_BYTE;
					next_out.out_byte = cmd.unit_id;
				end
				mrf_pkg::CMD_WORD: begin
					next_out.kind        = mrf_pkg::KIND_WORD;
					next_out.reg_address = cmd.address;
					next_out.reg_value   = cmd.value;
				end
				mrf_pkg::CMD_STATUS: begin
					next_out.kind   = mrf_pkg::KIND_STATUS;
					next_out.crc_ok = cmd.crc_ok;
					next_out.last   = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_active_q <= 1'b0;
			idx_q        <= mrf_pkg::REQ_IDX_SLAVE;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (req_active_q && out_free) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == mrf_pkg::REQ_IDX_CRC_HI) begin
					req_active_q <= 1'b0;
				end
			end else if (start_req) begin
				req_active_q <= 1'b1;
				idx_q        <= mrf_pkg::REQ_IDX_FUNC;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_out;
		end
		if (start_req) begin
			func_q <= cmd.function_code;
			addr_q <= cmd.address;
			cnt_q  <= cmd.value;
			crc_q  <= mrf_pkg::crc_byte(mrf_pkg::CRC_INIT, cmd.unit_id);
		end else if (req_active_q && out_free && (idx_q <= mrf_pkg::REQ_IDX_CNT_LO)) begin
			crc_q <= mrf_pkg::crc_byte(crc_q, req_byte);
		end
	end

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !req_active_q)
		else $error("queue popped while a request frame is being sent");

	a_idx_past_slave: assert property (@(posedge clk) disable iff (!arst_n)
		req_active_q |-> (idx_q != mrf_pkg::REQ_IDX_SLAVE))
		else $error("request serialiser at slave byte while active");

	a_frame_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && req_active_q && (idx_q == mrf_pkg::REQ_IDX_CRC_HI)) |=> !req_active_q)
		else $error("request serialiser did not stop after CRC high byte");

endmodule
